@@ design/assert_macros.svh @@
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle
`define RSSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the next cycle
`define RSSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/rssd_pkg.sv @@
// package: defaults, action codes, payload types and alu operation codes
`default_nettype none

package rssd_pkg;

  localparam int unsigned SpreadBitsDef   = 24;
  localparam int unsigned CountBitsDef    = 16;
  localparam int unsigned FractionBitsDef = 8;
  localparam int unsigned SqTotalBits     = 63;
  localparam int unsigned PriceBits       = 48;

  localparam logic [1:0] ActBook  = 2'd0;
  localparam logic [1:0] ActFinal = 2'd1;
  localparam logic [1:0] ActClear = 2'd2;
  localparam logic [1:0] ActSpare = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] instrument;
    logic [47:0] bid_price;
    logic [47:0] ask_price;
    logic        bid_present;
    logic        ask_present;
  } req_t;

  typedef struct packed {
    logic [31:0] spread_sigma;
    logic [15:0] sample_count;
    logic        too_few_samples;
  } rsp_t;

  typedef enum logic {
    AluAdd,
    AluSub
  } alu_op_e;

endpackage

`default_nettype wire

@@ design/rssd_alu.sv @@
// shared adder/subtractor with borrow out
`default_nettype none

module rssd_alu #(
  parameter int unsigned Width = 96
) (
  input  wire logic [Width-1:0]   a_i,
  input  wire logic [Width-1:0]   b_i,
  input  wire rssd_pkg::alu_op_e  op_i,
  output logic      [Width-1:0]   sum_o,
  output logic                    borrow_o
);

  logic             sub;
  logic [Width-1:0] b_eff;
  logic             carry;

  assign sub   = (op_i == rssd_pkg::AluSub);
  assign b_eff = sub ? ~b_i : b_i;
  assign {carry, sum_o} = {1'b0, a_i} + {1'b0, b_eff} + {{Width{1'b0}}, sub};
  assign borrow_o = sub & ~carry;

endmodule

`default_nettype wire

@@ design/running_spread_std_dev_core.sv @@
// top level: spread accumulators, sequencer and finalize arithmetic on one shared alu
//
// channel  dir  handshake                 payload
// req      in   req_valid_i / req_stall_o rssd_pkg::req_t
// rsp      out  rsp_valid_o / rsp_stall_i rssd_pkg::rsp_t
// cfg      in   cfg_valid_i / cfg_ready_o cfg_data_i (instrument select)
//
// counted book event: stall held through spread, square load, the serial square and both adds
// finalize: COUNT_BITS + SPREAD_BITS + COUNT_BITS multiply steps, RW root and RW divide
//   steps (RW = 48 by default), plus the abs, difference and done states
// short bar finalize: stall only in the done state; ignored events, clear and unused codes: none
// reset clears accumulators and select at once; no clearing pass
// a finalize waits in its last state while an earlier result is still stalled
`default_nettype none

module running_spread_std_dev_core #(
  parameter int unsigned SPREAD_BITS   = rssd_pkg::SpreadBitsDef,
  parameter int unsigned COUNT_BITS    = rssd_pkg::CountBitsDef,
  parameter int unsigned FRACTION_BITS = rssd_pkg::FractionBitsDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_valid_i,
  output logic                req_stall_o,
  input  wire rssd_pkg::req_t req_i,
  output logic                rsp_valid_o,
  input  wire logic           rsp_stall_i,
  output rssd_pkg::rsp_t      rsp_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [31:0]    cfg_data_i
);

  localparam int unsigned SqW   = rssd_pkg::SqTotalBits;
  localparam int unsigned StW   = SPREAD_BITS + COUNT_BITS;
  localparam int unsigned NqW   = COUNT_BITS + SqW;
  localparam int unsigned SsW   = 2 * StW;
  localparam int unsigned PreW  = (NqW > SsW) ? NqW : SsW;
  localparam int unsigned UW    = PreW + 2 * FRACTION_BITS;
  localparam int unsigned RW    = (UW + 1) / 2;
  localparam int unsigned DiffW = rssd_pkg::PriceBits + 1;
  localparam int unsigned StepW = $clog2(RW + 1);

  localparam logic signed [DiffW-1:0] SpreadHi =
    (DiffW'(1) <<< (SPREAD_BITS - 1)) - DiffW'(1);
  localparam logic signed [DiffW-1:0] SpreadLo = -SpreadHi - DiffW'(1);

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SSpread = 4'd1;
  localparam logic [3:0] SSqLoad = 4'd2;
  localparam logic [3:0] SSquare = 4'd3;
  localparam logic [3:0] SAddSum = 4'd4;
  localparam logic [3:0] SAddSq  = 4'd5;
  localparam logic [3:0] SMulNq  = 4'd6;
  localparam logic [3:0] SAbs    = 4'd7;
  localparam logic [3:0] SMulSs  = 4'd8;
  localparam logic [3:0] SDiff   = 4'd9;
  localparam logic [3:0] SSqrt   = 4'd10;
  localparam logic [3:0] SDiv    = 4'd11;
  localparam logic [3:0] SDone   = 4'd12;

  logic [3:0]                   state_q, state_d;
  rssd_pkg::req_t               req_q, req_d;
  logic [31:0]                  sel_q, sel_d;
  logic [StW-1:0]               sum_q, sum_d;
  logic [SqW-1:0]               sq_q, sq_d;
  logic [COUNT_BITS-1:0]        cnt_q, cnt_d;
  logic [SPREAD_BITS-1:0]       spread_q, spread_d;
  logic [UW-1:0]                acc_q, acc_d;
  logic [UW-1:0]                mcand_q, mcand_d;
  logic [UW-1:0]                x_q, x_d;
  logic [UW-1:0]                root_q, root_d;
  logic [UW-1:0]                one_q, one_d;
  logic [StW-1:0]               mplier_q, mplier_d;
  logic [StepW-1:0]             step_q, step_d;
  logic [RW-1:0]                dq_q, dq_d;
  logic [COUNT_BITS-1:0]        rem_q, rem_d;
  logic [31:0]                  std_q, std_d;
  logic                         few_q, few_d;
  logic                         rsp_valid_q, rsp_valid_d;
  rssd_pkg::rsp_t               rsp_q, rsp_d;
  logic                         rsp_load;

  logic [UW-1:0]                alu_a, alu_b, alu_sum;
  logic                         alu_borrow;
  rssd_pkg::alu_op_e            alu_op;

  logic signed [DiffW-1:0]      diff;
  logic signed [DiffW-1:0]      diff_sat;
  logic [SPREAD_BITS-1:0]       spread_mag;
  logic [StW-1:0]               sum_mag;
  logic [COUNT_BITS:0]          trial;
  logic                         mul_last;

  rssd_alu #(.Width(UW)) u_alu (
    .a_i      (alu_a),
    .b_i      (alu_b),
    .op_i     (alu_op),
    .sum_o    (alu_sum),
    .borrow_o (alu_borrow)
  );

  assign req_stall_o = (state_q != SIdle);
  assign cfg_ready_o = 1'b1;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  assign diff       = signed'(alu_sum[DiffW-1:0]);
  assign spread_mag = spread_q[SPREAD_BITS-1] ? (~spread_q + SPREAD_BITS'(1)) : spread_q;
  assign sum_mag    = sum_q[StW-1] ? alu_sum[StW-1:0] : sum_q;
  assign trial      = {rem_q, dq_q[RW-1]};
  assign mul_last   = (step_q == StepW'(1));

  always_comb begin
    if (diff > SpreadHi) begin
      diff_sat = SpreadHi;
    end else if (diff < SpreadLo) begin
      diff_sat = SpreadLo;
    end else begin
      diff_sat = diff;
    end
  end

  // alu operand selection
  always_comb begin
    alu_a  = acc_q;
    alu_b  = mcand_q;
    alu_op = rssd_pkg::AluAdd;
    unique case (state_q)
      SSpread: begin
        alu_a  = UW'(req_q.ask_price);
        alu_b  = UW'(req_q.bid_price);
        alu_op = rssd_pkg::AluSub;
      end
      SAddSum: begin
        alu_a = {{(UW-StW){sum_q[StW-1]}}, sum_q};
        alu_b = {{(UW-SPREAD_BITS){spread_q[SPREAD_BITS-1]}}, spread_q};
      end
      SAddSq: begin
        alu_a = UW'(sq_q);
        alu_b = acc_q;
      end
      SAbs: begin
        alu_a  = '0;
        alu_b  = {{(UW-StW){sum_q[StW-1]}}, sum_q};
        alu_op = rssd_pkg::AluSub;
      end
      SDiff: begin
        alu_a  = x_q;
        alu_b  = acc_q;
        alu_op = rssd_pkg::AluSub;
      end
      SSqrt: begin
        alu_a  = x_q;
        alu_b  = root_q | one_q;
        alu_op = rssd_pkg::AluSub;
      end
      SDiv: begin
        alu_a  = UW'(trial);
        alu_b  = UW'(cnt_q);
        alu_op = rssd_pkg::AluSub;
      end
      default: begin
        alu_a  = acc_q;
        alu_b  = mcand_q;
        alu_op = rssd_pkg::AluAdd;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    sel_d    = sel_q;
    sum_d    = sum_q;
    sq_d     = sq_q;
    cnt_d    = cnt_q;
    spread_d = spread_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    x_d      = x_q;
    root_d   = root_q;
    one_d    = one_q;
    mplier_d = mplier_q;
    step_d   = step_q;
    dq_d     = dq_q;
    rem_d    = rem_q;
    std_d    = std_q;
    few_d    = few_q;
    rsp_load = 1'b0;

    if (cfg_valid_i) begin
      sel_d = cfg_data_i;
    end

    unique case (state_q)
      SIdle: begin
        if (req_valid_i) begin
          req_d = req_i;
          unique case (req_i.action)
            rssd_pkg::ActBook: begin
              if (req_i.bid_present && req_i.ask_present && (req_i.instrument == sel_q)
                  && (cnt_q != {COUNT_BITS{1'b1}})) begin
                state_d = SSpread;
              end
            end
            rssd_pkg::ActFinal: begin
              few_d = (cnt_q < COUNT_BITS'(2));
              if (cnt_q < COUNT_BITS'(2)) begin
                std_d   = '0;
                state_d = SDone;
              end else begin
                acc_d    = '0;
                mcand_d  = UW'(sq_q);
                mplier_d = StW'(cnt_q);
                step_d   = StepW'(COUNT_BITS);
                state_d  = SMulNq;
              end
            end
            rssd_pkg::ActClear: begin
              sum_d = '0;
              sq_d  = '0;
              cnt_d = '0;
            end
            default: begin
              state_d = SIdle;
            end
          endcase
        end
      end
      SSpread: begin
        spread_d = diff_sat[SPREAD_BITS-1:0];
        state_d  = SSqLoad;
      end
      SSqLoad: begin
        acc_d    = '0;
        mcand_d  = UW'(spread_mag);
        mplier_d = StW'(spread_mag);
        step_d   = StepW'(SPREAD_BITS);
        state_d  = SSquare;
      end
      SSquare, SMulNq, SMulSs: begin
        if (mplier_q[0]) begin
          acc_d = alu_sum;
        end
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        step_d   = step_q - StepW'(1);
        if (mul_last) begin
          unique case (state_q)
            SSquare: state_d = SAddSum;
            SMulNq:  state_d = SAbs;
            default: state_d = SDiff;
          endcase
        end
      end
      SAddSum: begin
        sum_d   = alu_sum[StW-1:0];
        state_d = SAddSq;
      end
      SAddSq: begin
        sq_d    = alu_sum[SqW] ? {SqW{1'b1}} : alu_sum[SqW-1:0];
        cnt_d   = cnt_q + COUNT_BITS'(1);
        state_d = SIdle;
      end
      SAbs: begin
        x_d      = acc_q;
        acc_d    = '0;
        mcand_d  = UW'(sum_mag);
        mplier_d = sum_mag;
        step_d   = StepW'(StW);
        state_d  = SMulSs;
      end
      SDiff: begin
        if (alu_borrow) begin
          std_d   = '0;
          state_d = SDone;
        end else begin
          x_d     = alu_sum << (2 * FRACTION_BITS);
          root_d  = '0;
          one_d   = UW'(1) << (2 * (RW - 1));
          step_d  = StepW'(RW);
          state_d = SSqrt;
        end
      end
      SSqrt: begin
        if (!alu_borrow) begin
          x_d    = alu_sum;
          root_d = (root_q >> 1) | one_q;
        end else begin
          root_d = root_q >> 1;
        end
        one_d  = one_q >> 2;
        step_d = step_q - StepW'(1);
        if (mul_last) begin
          dq_d    = root_d[RW-1:0];
          rem_d   = '0;
          step_d  = StepW'(RW);
          state_d = SDiv;
        end
      end
      SDiv: begin
        rem_d  = alu_borrow ? trial[COUNT_BITS-1:0] : alu_sum[COUNT_BITS-1:0];
        dq_d   = {dq_q[RW-2:0], ~alu_borrow};
        step_d = step_q - StepW'(1);
        if (mul_last) begin
          std_d   = (|dq_d[RW-1:32]) ? 32'hFFFF_FFFF : dq_d[31:0];
          state_d = SDone;
        end
      end
      SDone: begin
        if (!rsp_valid_q || !rsp_stall_i) begin
          rsp_load = 1'b1;
          state_d  = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_comb begin
    rsp_d = rsp_q;
    if (rsp_load) begin
      rsp_d.spread_sigma    = std_q;
      rsp_d.sample_count    = 16'(cnt_q);
      rsp_d.too_few_samples = few_q;
    end
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_load) begin
      rsp_valid_d = 1'b1;
    end else if (!rsp_stall_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      sel_q       <= '0;
      sum_q       <= '0;
      sq_q        <= '0;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      sum_q       <= sum_d;
      sq_q        <= sq_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    spread_q <= spread_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    x_q      <= x_d;
    root_q   <= root_d;
    one_q    <= one_d;
    mplier_q <= mplier_d;
    step_q   <= step_d;
    dq_q     <= dq_d;
    rem_q    <= rem_d;
    std_q    <= std_d;
    few_q    <= few_d;
    rsp_q    <= rsp_d;
  end

endmodule

`default_nettype wire

@@ design/rssd_checker.sv @@
// port-level checker for the spread deviation core and its bind
`default_nettype none
`include "assert_macros.svh"

module rssd_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           req_valid_i,
  input wire logic           req_stall_o,
  input wire rssd_pkg::req_t req_i,
  input wire logic           rsp_valid_o,
  input wire logic           rsp_stall_i,
  input wire rssd_pkg::rsp_t rsp_o
);

  logic req_take;
  logic final_take;
  logic clear_take;
  logic few_show;
  logic few_ok;

  assign req_take   = req_valid_i && !req_stall_o;
  assign final_take = req_take && (req_i.action == rssd_pkg::ActFinal);
  assign clear_take = req_take && (req_i.action == rssd_pkg::ActClear);
  assign few_show   = rsp_valid_o && rsp_o.too_few_samples;
  assign few_ok     = (rsp_o.spread_sigma == 32'd0) && (rsp_o.sample_count < 16'd2);

  `RSSD_ASSERT_NEXT(a_rsp_hold, rsp_valid_o && rsp_stall_i, rsp_valid_o, "result dropped")
  `RSSD_ASSERT_NOW(a_few_zero, few_show, few_ok, "short bar result not zero")
  `RSSD_ASSERT_NEXT(a_final_busy, final_take, req_stall_o, "finalize request not held")
  `RSSD_ASSERT_NEXT(a_clear_quick, clear_take, !req_stall_o, "clear request left core busy")

endmodule

bind running_spread_std_dev_core rssd_checker u_rssd_checker (.*);

`default_nettype wire

@@ verif/rssd_checker.sv @@
// checker: spread statistics predictor and result comparison for the core
`default_nettype none

module rssd_tb_checker (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_valid_i,
  input  wire logic           req_stall_i,
  input  wire rssd_pkg::req_t req_i,
  input  wire logic           rsp_valid_i,
  input  wire logic           rsp_stall_i,
  input  wire rssd_pkg::rsp_t rsp_i,
  input  wire logic           cfg_valid_i,
  input  wire logic           cfg_ready_i,
  input  wire logic [31:0]    cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  checked_o
);

  localparam longint SpreadHi = (64'sd1 <<< (rssd_pkg::SpreadBitsDef - 1)) - 1;
  localparam longint SpreadLo = -SpreadHi - 1;
  localparam int unsigned CountMax = (1 << rssd_pkg::CountBitsDef) - 1;
  localparam logic [62:0] SquareMax = {63{1'b1}};

  logic [31:0]        sel_instr;
  logic signed [39:0] sum_spread;
  logic [62:0]        sum_square;
  logic [15:0]        n_events;
  rssd_pkg::rsp_t     std_dev_q[$];

  function automatic logic [63:0] wide_root(logic [127:0] x);
    logic [63:0] root;
    logic [63:0] cand;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (x >= {64'd0, cand} * {64'd0, cand}) root = cand;
    end
    return root;
  endfunction

  function automatic rssd_pkg::rsp_t std_dev_of(logic signed [39:0] s, logic [62:0] sq,
                                                logic [15:0] n);
    rssd_pkg::rsp_t r;
    logic [127:0] nq;
    logic [127:0] ss;
    logic [63:0] mag;
    logic [63:0] q;
    r.sample_count = n;
    r.too_few_samples = (n < 2);
    r.spread_sigma = '0;
    if (n >= 2) begin
      mag = s < 0 ? 64'(-s) : 64'(s);
      nq = {112'd0, n} * {65'd0, sq};
      ss = {64'd0, mag} * {64'd0, mag};
      if (nq >= ss) begin
        q = wide_root((nq - ss) << (2 * rssd_pkg::FractionBitsDef)) / n;
        r.spread_sigma = q > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : q[31:0];
      end
    end
    return r;
  endfunction

  task automatic apply_request(rssd_pkg::req_t r);
    longint s;
    logic [63:0] sq;
    case (r.action)
      rssd_pkg::ActBook: begin
        if (r.bid_present && r.ask_present && r.instrument == sel_instr &&
            n_events < CountMax) begin
          s = longint'({16'd0, r.ask_price}) - longint'({16'd0, r.bid_price});
          if (s > SpreadHi) s = SpreadHi;
          if (s < SpreadLo) s = SpreadLo;
          sq = 64'(s * s);
          sum_spread += 40'(s);
          sum_square = ({1'b0, sum_square} + sq > {1'b0, SquareMax}) ? SquareMax
                       : 63'({1'b0, sum_square} + sq);
          n_events++;
        end
      end
      rssd_pkg::ActFinal: std_dev_q.push_back(std_dev_of(sum_spread, sum_square, n_events));
      rssd_pkg::ActClear: begin
        sum_spread = '0;
        sum_square = '0;
        n_events = '0;
      end
      default: ;
    endcase
  endtask

  // values are stable from the falling edge to the rising edge that accepts them
  always @(negedge clk_i or negedge rst_ni) begin
    rssd_pkg::rsp_t e;
    if (!rst_ni) begin
      sel_instr = '0;
      sum_spread = '0;
      sum_square = '0;
      n_events = '0;
      std_dev_q.delete();
      fail_count_o = 0;
      checked_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) sel_instr = cfg_data_i;
      if (req_valid_i && !req_stall_i) apply_request(req_i);
      if (rsp_valid_i && !rsp_stall_i) begin
        if (std_dev_q.size() == 0) begin
          $error("unexpected result: %p", rsp_i);
          fail_count_o++;
        end else begin
          e = std_dev_q.pop_front();
          checked_o++;
          if (rsp_i.spread_sigma !== e.spread_sigma) begin
            $error("spread_sigma: expected %0d, actual %0d", e.spread_sigma,
                   rsp_i.spread_sigma);
            fail_count_o++;
          end
          if (rsp_i.sample_count !== e.sample_count) begin
            $error("sample_count: expected %0d, actual %0d", e.sample_count,
                   rsp_i.sample_count);
            fail_count_o++;
          end
          if (rsp_i.too_few_samples !== e.too_few_samples) begin
            $error("too_few_samples: expected %0b, actual %0b", e.too_few_samples,
                   rsp_i.too_few_samples);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = std_dev_q.size();
  end

endmodule

`default_nettype wire

@@ verif/tb_running_spread_std_dev_core.sv @@
// testbench top: stimulus, idling and verdict for the spread deviation core
`default_nettype none

module tb_running_spread_std_dev_core;

  localparam longint CycleLimit = 8_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_stall_o;
  rssd_pkg::req_t req_i = '0;
  logic rsp_valid_o;
  logic rsp_stall_i = 1'b0;
  rssd_pkg::rsp_t rsp_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [31:0] cfg_data_i = '0;
  int fail_count, pending, checked;
  longint cycles = 0;
  logic calm = 1'b0;
  logic [31:0] cur_sel = '0;
  int n_req = 0;

  always #6 clk_i = ~clk_i;

  running_spread_std_dev_core dut (
    .clk_i, .rst_ni, .req_valid_i, .req_stall_o, .req_i,
    .rsp_valid_o, .rsp_stall_i, .rsp_o, .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  rssd_tb_checker checker_i (
    .clk_i, .rst_ni, .req_valid_i, .req_stall_i(req_stall_o), .req_i,
    .rsp_valid_i(rsp_valid_o), .rsp_stall_i, .rsp_i(rsp_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("running_spread_std_dev_core: mismatch");
      $finish;
    end
  end

  // result side stalls
  initial begin
    int n;
    logic go;
    @(posedge rst_ni);
    forever begin
      n = calm ? 0 : $urandom_range(0, 7);
      if (n > 0) begin
        rsp_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      rsp_stall_i <= 1'b0;
      do begin
        @(negedge clk_i);
        go = rsp_valid_o && !rsp_stall_i;
        @(posedge clk_i);
      end while (!go);
    end
  end

  task automatic send(rssd_pkg::req_t r, bit no_gap = 0);
    int gap;
    logic go;
    gap = (calm || no_gap) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= r;
    do begin
      @(negedge clk_i);
      go = !req_stall_o;
      @(posedge clk_i);
    end while (!go);
    n_req++;
  endtask

  task automatic book(logic [31:0] inst, logic [47:0] bid, logic [47:0] ask,
                      logic bp = 1, logic ap = 1, bit no_gap = 0);
    rssd_pkg::req_t r;
    r = '{action: rssd_pkg::ActBook, instrument: inst, bid_price: bid, ask_price: ask,
          bid_present: bp, ask_present: ap};
    send(r, no_gap);
  endtask

  task automatic other(logic [1:0] act);
    rssd_pkg::req_t r;
    r = '{action: act, instrument: $urandom, bid_price: 48'({$urandom, $urandom}),
          ask_price: 48'({$urandom, $urandom}), bid_present: 1'($urandom),
          ask_present: 1'($urandom)};
    send(r);
  endtask

  task automatic set_instrument(logic [31:0] v);
    logic go;
    req_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do begin
      @(negedge clk_i);
      go = cfg_ready_o;
      @(posedge clk_i);
    end while (!go);
    cfg_valid_i <= 1'b0;
    cur_sel = v;
  endtask

  task automatic random_item();
    int k;
    logic [47:0] bid, ask;
    k = $urandom_range(0, 99);
    bid = 48'({$urandom, $urandom});
    if (k < 8) other(rssd_pkg::ActFinal);
    else if (k < 10) other(rssd_pkg::ActClear);
    else if (k < 11) other(rssd_pkg::ActSpare);
    else begin
      if (k < 70) ask = bid + 48'($urandom_range(0, 4000)) - 48'd1000;
      else if (k < 80) ask = bid + 48'($signed($urandom) >>> 7);
      else ask = 48'({$urandom, $urandom});
      book(k < 90 ? cur_sel : ($urandom_range(0, 1) ? $urandom : cur_sel ^ 32'd1),
           bid, ask, k < 95 ? 1'b1 : 1'($urandom), k < 95 ? 1'b1 : 1'($urandom));
    end
  endtask

  initial begin
    logic [47:0] top;
    top = '1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // too few samples, extremes, presence and instrument filtering, spare code and clear
    other(rssd_pkg::ActFinal);
    book(0, 48'd100, 48'd105);
    other(rssd_pkg::ActFinal);
    book(0, 48'd0, top);
    book(0, top, 48'd0);
    book(0, top, top);
    book(0, 48'd0, 48'd0);
    book(0, 48'd5, 48'd9, 0, 1);
    book(0, 48'd5, 48'd9, 1, 0);
    book(0, 48'd5, 48'd9, 0, 0);
    book(32'd1, 48'd5, 48'd9);
    other(rssd_pkg::ActSpare);
    other(rssd_pkg::ActFinal);
    other(rssd_pkg::ActFinal);
    other(rssd_pkg::ActClear);
    other(rssd_pkg::ActFinal);
    book(0, 48'd1000, 48'd1003);
    book(0, 48'd1000, 48'd1003);
    other(rssd_pkg::ActFinal);

    set_instrument(32'hFFFF_FFFF);
    book(32'hFFFF_FFFF, 48'd10, 48'd30);
    book(32'd0, 48'd10, 48'd90);
    book(32'hFFFF_FFFF, 48'd10, 48'd11);
    other(rssd_pkg::ActFinal);

    for (int ph = 0; ph < 8; ph++) begin
      set_instrument(ph == 7 ? 32'd0 : $urandom);
      for (int i = 0; i < 100; i++) begin
        if (i % 25 == 0) calm = ($urandom_range(0, 3) == 0);
        random_item();
      end
      calm = 1'b0;
      other(rssd_pkg::ActFinal);
    end

    req_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("run covered %0d requests over several instrument selects, %0d results checked",
             n_req, checked);
    $display("directed extremes, presence and instrument filtering and clears included");
    if (fail_count == 0) $display("running_spread_std_dev_core: match");
    else $display("running_spread_std_dev_core: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+design
design/rssd_pkg.sv
design/rssd_alu.sv
design/running_spread_std_dev_core.sv
design/rssd_checker.sv
verif/rssd_checker.sv
verif/tb_running_spread_std_dev_core.sv
